### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rstn, expr)
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

### rtl/lssr_pkg.sv
// ----------------------------------------------------------------------------
// Scope renderer package
// Constants, register indexes and sequencer states of the scope renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package lssr_pkg;

    localparam int CHANNELS      = 64;
    localparam int CHAN_BITS     = $clog2(CHANNELS);
    localparam int MAX_WIDTH     = 64;
    localparam int WIDTH_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int SAMPLE_WORDS  = 65536;
    localparam int ADDR_BITS     = $clog2(SAMPLE_WORDS);
    localparam int FRACTION_BITS = 5;
    localparam int POS_BITS      = 24;
    localparam int DIV_BITS      = 16 + FRACTION_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_BITS + 1);
    localparam int IN_DATA_BITS  = 136;

    localparam logic [15:0] PERIOD_BASE_RESET = 16'd6847;

    localparam logic REG_PERIOD_BASE   = 1'b0;
    localparam logic REG_MODULE_LOADED = 1'b1;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_RENDER = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_STEP,
        ST_DIV_TRANS,
        ST_FETCH,
        ST_HOLD
    } lssr_state_t;

endpackage

`default_nettype wire

### rtl/looped_sample_scope_renderer.sv
// ----------------------------------------------------------------------------
// Looped sample scope renderer
// Sample memory plus per-channel playback positions rendered to scope bytes.
// ----------------------------------------------------------------------------
// The slave channel takes load requests (tuser 0), which write one sample
// point, and render requests (tuser 1), which produce up to 64 signed bytes
// on the master channel with tlast on the final one.
// A render request first runs the playback step division on the shared
// one-bit-per-cycle divider, then, for a sample with a one-shot part, the
// transient count division. Each value is then fetched in ST_FETCH and
// offered in ST_HOLD until the receiver accepts it; error requests skip the
// divisions and memory reads and offer zero values from ST_HOLD alone. The
// block takes no new request until the last value of the current one has
// been accepted, and a stalled receiver simply holds it.
// Reset clears the channel positions to zero, restores the period base and
// clears the module loaded flag; sample memory contents are kept undefined.
// Configuration writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module looped_sample_scope_renderer
    import lssr_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_we,
    input  wire logic                    cfg_index,
    input  wire logic [15:0]             cfg_wdata,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // mem_addr, mem_data, trigger, period, channel, width, sample_base,
    // sample_len, loop_start, loop_end, sample_flags, zero padding
    input  wire logic [IN_DATA_BITS-1:0] s_tdata,
    // kind
    input  wire logic                    s_tuser,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // scope_value
    output logic [7:0]                   m_tdata,
    output logic                         m_tlast
);

    lssr_state_t state_reg, state_next;

    logic [15:0] period_base_reg;
    logic        module_loaded_reg;

    logic [POS_BITS-1:0]  pos_mem [CHANNELS];
    logic [CHANNELS-1:0]  pos_valid_reg;
    logic [POS_BITS-1:0]  pos_rd_reg;
    logic                 pos_rd_valid_reg;
    logic [15:0]          sample_mem [SAMPLE_WORDS];
    logic [15:0]          rd_data_reg;

    logic                 trig_reg, looping_reg, wide_reg, err_reg, zero_reg;
    logic [CHAN_BITS-1:0] chan_reg;
    logic [WIDTH_BITS-1:0] width_reg, idx_reg, limit_reg;
    logic [15:0]          base_reg, slen_reg;
    logic [DIV_BITS-1:0]  lps_reg, lpe_reg, step_reg;
    logic [POS_BITS-1:0]  pos_reg;

    logic [DIV_BITS-1:0]     div_q_reg, div_d_reg, div_r_reg;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg;
    logic [DIV_BITS:0]       div_trial;
    logic                    div_done;

    logic [15:0]          in_mem_addr, in_mem_data, in_period, in_base, in_slen;
    logic [15:0]          in_lps, in_lpe;
    logic                 in_trig;
    logic [CHAN_BITS-1:0] in_chan;
    logic [7:0]           in_width;
    logic [2:0]           in_flags;
    logic [WIDTH_BITS-1:0] w_clamped;
    logic                 in_acc, render_go, render_err;

    logic [POS_BITS-1:0]  cur_pos, pos0, end_pos, p1, p2, pos_step;
    logic                 restart, in_trans, do_read, last_idx;
    logic [ADDR_BITS-1:0] rd_addr;

    assign in_mem_addr = s_tdata[15:0];
    assign in_mem_data = s_tdata[31:16];
    assign in_trig     = s_tdata[32];
    assign in_period   = s_tdata[48:33];
    assign in_chan     = s_tdata[54:49];
    assign in_width    = s_tdata[62:55];
    assign in_base     = s_tdata[78:63];
    assign in_slen     = s_tdata[94:79];
    assign in_lps      = s_tdata[110:95];
    assign in_lpe      = s_tdata[126:111];
    assign in_flags    = s_tdata[129:127];

    assign w_clamped  = (in_width > 8'(MAX_WIDTH)) ? WIDTH_BITS'(MAX_WIDTH)
                                                   : WIDTH_BITS'(in_width);
    assign in_acc     = s_tvalid && s_tready;
    assign render_go  = in_acc && (s_tuser == KIND_RENDER) && module_loaded_reg
                        && (in_width != 8'd0);
    assign render_err = (in_period == 16'd0) || !in_flags[2] || (in_slen == 16'd0);

    assign div_trial = {div_r_reg, div_q_reg[DIV_BITS-1]};
    assign div_done  = (div_cnt_reg == DIV_CNT_BITS'(DIV_BITS));

    assign cur_pos = pos_rd_valid_reg ? pos_rd_reg : '0;
    assign restart = trig_reg ||
                     (cur_pos[POS_BITS-1:FRACTION_BITS] >=
                      (POS_BITS-FRACTION_BITS)'(slen_reg));
    assign pos0    = restart ? '0 : cur_pos;
    assign end_pos = looping_reg ? POS_BITS'(lps_reg)
                                 : POS_BITS'({slen_reg, {FRACTION_BITS{1'b0}}});

    assign in_trans = idx_reg < limit_reg;
    assign do_read  = in_trans || looping_reg;
    assign last_idx = (idx_reg == width_reg - WIDTH_BITS'(1));
    assign rd_addr  = base_reg + pos_reg[FRACTION_BITS +: ADDR_BITS];
    assign p1       = pos_reg + POS_BITS'(step_reg);

    always_comb begin
        p2 = p1;
        if (!in_trans && p1 >= POS_BITS'(lpe_reg)) begin
            p2 = POS_BITS'(lps_reg) + (p1 - POS_BITS'(lpe_reg));
            if (p2 >= POS_BITS'(lpe_reg)) begin
                p2 = POS_BITS'(lps_reg);
            end
        end
        pos_step = do_read ? p2 : pos_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (render_go) begin
                    state_next = render_err ? ST_HOLD : ST_DIV_STEP;
                end
            end
            ST_DIV_STEP: begin
                if (div_done) begin
                    if (div_q_reg != '0 && end_pos > pos0) begin
                        state_next = ST_DIV_TRANS;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_DIV_TRANS: begin
                if (div_done) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (m_tready) begin
                    if (last_idx) begin
                        state_next = ST_IDLE;
                    end else if (!err_reg) begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_HOLD);
        m_tlast  = last_idx;
        if (zero_reg || err_reg) begin
            m_tdata = 8'd0;
        end else begin
            m_tdata = wide_reg ? rd_data_reg[15:8] : rd_data_reg[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            period_base_reg   <= PERIOD_BASE_RESET;
            module_loaded_reg <= 1'b0;
            pos_valid_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_PERIOD_BASE:   period_base_reg   <= cfg_wdata;
                    REG_MODULE_LOADED: module_loaded_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (state_reg == ST_FETCH && last_idx) begin
                pos_valid_reg[chan_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && s_tuser == KIND_LOAD) begin
            sample_mem[in_mem_addr] <= in_mem_data;
        end
        if (state_reg == ST_FETCH) begin
            rd_data_reg <= sample_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FETCH && last_idx) begin
            pos_mem[chan_reg] <= pos_step;
        end
        if (in_acc) begin
            pos_rd_reg       <= pos_mem[in_chan];
            pos_rd_valid_reg <= pos_valid_reg[in_chan];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
            idx_reg     <= '0;
        end else begin
            if (render_go) begin
                trig_reg    <= in_trig;
                looping_reg <= in_flags[0];
                wide_reg    <= in_flags[1];
                err_reg     <= render_err;
                zero_reg    <= 1'b0;
                chan_reg    <= in_chan;
                width_reg   <= w_clamped;
                base_reg    <= in_base;
                slen_reg    <= in_slen;
                lps_reg     <= {in_lps, {FRACTION_BITS{1'b0}}};
                lpe_reg     <= {in_lpe, {FRACTION_BITS{1'b0}}};
                limit_reg   <= '0;
                idx_reg     <= '0;
                div_q_reg   <= {period_base_reg, {FRACTION_BITS{1'b0}}};
                div_d_reg   <= DIV_BITS'(in_period);
                div_r_reg   <= '0;
                div_cnt_reg <= '0;
            end
            if ((state_reg == ST_DIV_STEP || state_reg == ST_DIV_TRANS) && !div_done) begin
                if (div_trial >= {1'b0, div_d_reg}) begin
                    div_r_reg <= DIV_BITS'(div_trial - {1'b0, div_d_reg});
                    div_q_reg <= {div_q_reg[DIV_BITS-2:0], 1'b1};
                end else begin
                    div_r_reg <= DIV_BITS'(div_trial);
                    div_q_reg <= {div_q_reg[DIV_BITS-2:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg + DIV_CNT_BITS'(1);
            end
            if (state_reg == ST_DIV_STEP && div_done) begin
                step_reg    <= div_q_reg;
                pos_reg     <= pos0;
                div_q_reg   <= DIV_BITS'(end_pos - pos0);
                div_d_reg   <= div_q_reg;
                div_r_reg   <= '0;
                div_cnt_reg <= '0;
            end
            if (state_reg == ST_DIV_TRANS && div_done) begin
                limit_reg <= (div_q_reg > DIV_BITS'(width_reg)) ? width_reg
                                                               : WIDTH_BITS'(div_q_reg);
            end
            if (state_reg == ST_FETCH) begin
                zero_reg <= !do_read;
                pos_reg  <= pos_step;
            end
            if (state_reg == ST_HOLD && m_tready && !last_idx) begin
                idx_reg <= idx_reg + WIDTH_BITS'(1);
            end
        end
    end

    `ASSERT_ALWAYS(a_one_side, aclk, aresetn, !(s_tready && m_tvalid))
    `ASSERT_NEXT(a_last_frees, aclk, aresetn, m_tvalid && m_tready && m_tlast, s_tready)
    `ASSERT_ALWAYS(a_div_bound, aclk, aresetn, div_cnt_reg <= DIV_CNT_BITS'(DIV_BITS))
    `ASSERT_IMPLIES(a_idx_range, aclk, aresetn, m_tvalid, idx_reg < width_reg)

endmodule

`default_nettype wire
